FILE: rtl/core/spq_pkg.sv
// spq_pkg: types, codes and defaults shared by the sorted priority queue
// depends on nothing; used by every file in rtl/core by scoped names

package spq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 32;
    localparam int OCC_W     = 7;

    // req_type codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic                      req_type;
        logic signed [VALUE_W-1:0] value;
    } spq_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] front_value;
        logic [OCC_W-1:0]          occupancy;
        logic [1:0]                status;
    } spq_rsp_t;

    // broadcast from the controller to every cell of the row
    typedef struct packed {
        logic                      fire;
        logic                      remove;
        logic                      descending;
        logic signed [VALUE_W-1:0] value;
    } spq_bcast_t;

endpackage

FILE: rtl/core/spq_cell.sv
// spq_cell: one slot of the sorted row, holds one entry and compares it
// against the broadcast value; depends on spq_pkg

module spq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                               clk,
    input  spq_pkg::spq_bcast_t                ctl,
    input  logic [CW-1:0]                      count,
    input  logic signed [spq_pkg::VALUE_W-1:0] prev_data,
    input  logic signed [spq_pkg::VALUE_W-1:0] next_data,
    input  logic                               keep_here,
    input  logic                               keep_prev,
    output logic signed [spq_pkg::VALUE_W-1:0] data,
    output logic signed [spq_pkg::VALUE_W-1:0] data_next,
    output logic                               stop
);

    logic signed [spq_pkg::VALUE_W-1:0] data_reg;
    logic                               in_use;
    logic                               passes;

    assign in_use = CW'(IDX) < count;

    // new value strictly ahead of this entry under the current order
    assign passes = ctl.descending ? (data_reg < ctl.value) : (ctl.value < data_reg);

    // a held entry that the new value does not pass blocks it here
    assign stop = in_use & ~passes;

    always_comb
    begin
        if (!ctl.fire)
        begin
            data_next = data_reg;
        end
        else if (ctl.remove)
        begin
            data_next = next_data;
        end
        else if (keep_here)
        begin
            data_next = data_reg;
        end
        else if (keep_prev)
        begin
            data_next = ctl.value;
        end
        else
        begin
            data_next = prev_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: rtl/core/spq_ctrl.sv
// spq_ctrl: handshake, entry count, order register and result register
// depends on spq_pkg

module spq_ctrl #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  spq_pkg::spq_req_t                  req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output spq_pkg::spq_rsp_t                  rsp,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic signed [spq_pkg::VALUE_W-1:0] front_next,
    output spq_pkg::spq_bcast_t                ctl,
    output logic [CW-1:0]                      count
);

    logic                  count_en;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  desc_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    spq_pkg::spq_rsp_t     rsp_reg;
    spq_pkg::spq_rsp_t     rsp_next;
    logic                  accept;
    logic                  is_remove;
    logic                  err_empty;
    logic                  err_full;

    assign req_ready = ~rsp_valid_reg | rsp_ready;
    assign accept    = req_valid & req_ready;
    assign is_remove = (req.req_type == spq_pkg::REQ_REMOVE);
    assign err_empty = is_remove & (count_reg == '0);
    assign err_full  = ~is_remove & (count_reg == CW'(DEPTH));

    always_comb
    begin
        ctl.fire       = accept & ~err_empty & ~err_full;
        ctl.remove     = is_remove;
        ctl.descending = desc_reg;
        ctl.value      = req.value;
    end

    assign count_en = ctl.fire;

    always_comb
    begin
        count_next = count_reg;
        if (count_en)
        begin
            count_next = is_remove ? (count_reg - CW'(1)) : (count_reg + CW'(1));
        end
    end

    always_comb
    begin
        rsp_next.front_value = (count_next != '0) ? front_next : '0;
        rsp_next.occupancy   = spq_pkg::OCC_W'(count_next);
        if (err_empty)
        begin
            rsp_next.status = spq_pkg::STAT_EMPTY;
        end
        else if (err_full)
        begin
            rsp_next.status = spq_pkg::STAT_FULL;
        end
        else
        begin
            rsp_next.status = spq_pkg::STAT_OK;
        end
    end

    assign rsp_valid_next = accept | (rsp_valid_reg & ~rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            desc_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                desc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign count     = count_reg;

endmodule

FILE: rtl/core/sorted_priority_queue.sv
// sorted_priority_queue: top level, a row of DEPTH cells kept in order
// depends on spq_pkg, spq_cell and spq_ctrl
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  req     | in        | req_valid / req_ready  | spq_req_t (req_type, value)
//  rsp     | out       | rsp_valid / rsp_ready  | spq_rsp_t (front, occ, status)
//  cfg     | in        | cfg_we, no wait        | cfg_wdata (descending order)
//
// every cell compares its entry with the new value in the same cycle, so an
// item can be taken every cycle and its result is shown in the next cycle
// req_ready drops only while a result waits and rsp_ready is low
// reset clears the count, order and result valid; entries need no clearing

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  spq_pkg::spq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output spq_pkg::spq_rsp_t rsp,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);

    localparam int CW = $clog2(DEPTH + 1);

    spq_pkg::spq_bcast_t                ctl;
    logic [CW-1:0]                      count;
    logic signed [spq_pkg::VALUE_W-1:0] cell_data [DEPTH];
    logic signed [spq_pkg::VALUE_W-1:0] front_next;
    logic [DEPTH-1:0]                   stop;
    logic [DEPTH-1:0]                   keep;

    spq_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .front_next (front_next),
        .ctl        (ctl),
        .count      (count)
    );

    // on an insert, a cell keeps its entry when it or any cell behind it blocks the new value
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            keep[i] = |(stop >> i);
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [spq_pkg::VALUE_W-1:0] prev_d;
        logic signed [spq_pkg::VALUE_W-1:0] next_d;
        logic                               keep_p;

        if (i == 0)
        begin : g_head
            assign prev_d = ctl.value;
            assign keep_p = 1'b1;
        end
        else
        begin : g_body
            assign prev_d = cell_data[i-1];
            assign keep_p = keep[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_d = cell_data[i];
        end
        else
        begin : g_mid
            assign next_d = cell_data[i+1];
        end

        if (i == 0)
        begin : g_front
            spq_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .count     (count),
                .prev_data (prev_d),
                .next_data (next_d),
                .keep_here (keep[i]),
                .keep_prev (keep_p),
                .data      (cell_data[i]),
                .data_next (front_next),
                .stop      (stop[i])
            );
        end
        else
        begin : g_rest
            spq_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .count     (count),
                .prev_data (prev_d),
                .next_data (next_d),
                .keep_here (keep[i]),
                .keep_prev (keep_p),
                .data      (cell_data[i]),
                .data_next (),
                .stop      (stop[i])
            );
        end
    end

endmodule

FILE: rtl/core/spq_checker.sv
// spq_checker: port-level assertions for sorted_priority_queue, bound to it
// depends on spq_pkg and sorted_priority_queue

module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input spq_pkg::spq_req_t req,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input spq_pkg::spq_rsp_t rsp,
    input logic              cfg_we,
    input logic              cfg_wdata
);

    // a waiting result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    // every accepted item gives a result in the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("no result after accepted item");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.occupancy == '0 && DEPTH < 128 |-> rsp.front_value == '0)
        else $error("front not zero on empty queue");

    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == spq_pkg::STAT_EMPTY |-> rsp.occupancy == '0)
        else $error("remove error with entries held");

    a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == spq_pkg::STAT_FULL
            |-> rsp.occupancy == spq_pkg::OCC_W'(DEPTH))
        else $error("full error below depth");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
